@@ design/dsv_pkg.sv @@
// shared types, codes and constants for the dial string validator
`default_nettype none

package dsv_pkg;

  // string length limit and counter sizing
  localparam int MAX_LEN = 99;
  localparam int CNT_W = 7;
  localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};

  // widths of fixed fields
  localparam int SYM_W = 8;
  localparam int POS_W = 8;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 8;

  // item kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END = 1'b1;

  // grade codes
  localparam logic [1:0] GRADE_FATAL = 2'd0;
  localparam logic [1:0] GRADE_INVALID = 2'd1;
  localparam logic [1:0] GRADE_TOLERABLE = 2'd2;
  localparam logic [1:0] GRADE_VALID = 2'd3;

  // no dialable symbol seen
  localparam logic signed [POS_W-1:0] POS_NONE = -8'sd2;

  // calling tone setting that forbids the caret
  localparam logic [2:0] CARET_REJECT_MODE = 3'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ABCD_REJECT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_SWITCH_REJECT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CALLING_TONE_MODE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LENIENT_VALIDATION = 8'd3;

  // dialing mode chosen by the first character
  typedef enum logic [1:0] {
    PFX_WAIT  = 2'd0,
    PFX_TONE  = 2'd1,
    PFX_PULSE = 2'd2,
    PFX_NONE  = 2'd3
  } prefix_t;

  // character classes
  typedef enum logic [2:0] {
    CLS_DIAL  = 3'd0,
    CLS_PAUSE = 3'd1,
    CLS_ABCD  = 3'd2,
    CLS_TONE  = 3'd3,
    CLS_PULSE = 3'd4,
    CLS_CARET = 3'd5,
    CLS_SEMI  = 3'd6,
    CLS_OTHER = 3'd7
  } cls_t;

  // configuration bundle
  typedef struct packed {
    logic       abcd_reject;
    logic       mode_switch_reject;
    logic [2:0] calling_tone_mode;
    logic       lenient_validation;
  } cfg_t;

  // result bundle
  typedef struct packed {
    logic [1:0]              grade;
    logic                    rejected;
    logic signed [POS_W-1:0] last_pos;
  } res_t;

endpackage

`default_nettype wire

@@ design/dsv_classify.sv @@
// character classifier for dial string symbols
`default_nettype none

module dsv_classify (
  input  wire logic [dsv_pkg::SYM_W-1:0] symbol,
  output dsv_pkg::cls_t                  cls
);

  // byte to class lookup
  always_comb begin
    case (symbol)
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34,
      8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
      8'h2A, 8'h23, 8'h21:                       cls = dsv_pkg::CLS_DIAL;
      8'h20, 8'h24, 8'h28, 8'h29, 8'h2C,
      8'h2D, 8'h40, 8'h57, 8'h77:                cls = dsv_pkg::CLS_PAUSE;
      8'h41, 8'h42, 8'h43, 8'h44,
      8'h61, 8'h62, 8'h63, 8'h64:                cls = dsv_pkg::CLS_ABCD;
      8'h54, 8'h74:                              cls = dsv_pkg::CLS_TONE;
      8'h50, 8'h70:                              cls = dsv_pkg::CLS_PULSE;
      8'h5E:                                     cls = dsv_pkg::CLS_CARET;
      8'h3B:                                     cls = dsv_pkg::CLS_SEMI;
      default:                                   cls = dsv_pkg::CLS_OTHER;
    endcase
  end

endmodule

`default_nettype wire

@@ design/dsv_tracker.sv @@
// per-string state: mode, count, running grade, last dialable, pending semicolon
`default_nettype none

module dsv_tracker (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      fire,
  input  wire logic                      kind,
  input  wire logic [dsv_pkg::SYM_W-1:0] symbol,
  input  wire dsv_pkg::cfg_t             cfg,
  output dsv_pkg::res_t                  res
);

  dsv_pkg::prefix_t                    mode_r, mode_nxt;
  logic [dsv_pkg::CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [1:0]                          grade_r, grade_nxt;
  logic signed [dsv_pkg::POS_W-1:0]    last_r, last_nxt;
  logic                                semi_r, semi_nxt;
  dsv_pkg::cls_t                       cls;
  logic                                illegal;
  logic                                dialable;
  logic [1:0]                          floor_grade;

  dsv_classify u_cls (
    .symbol (symbol),
    .cls    (cls)
  );

  // legality of one character after the mode letter
  always_comb begin
    illegal  = semi_r;
    dialable = 1'b0;
    case (cls)
      dsv_pkg::CLS_DIAL:  dialable = 1'b1;
      dsv_pkg::CLS_PAUSE: ;
      dsv_pkg::CLS_ABCD: begin
        if (cfg.abcd_reject) illegal = 1'b1;
        else dialable = 1'b1;
      end
      dsv_pkg::CLS_TONE:
        if (mode_r != dsv_pkg::PFX_TONE && cfg.mode_switch_reject) illegal = 1'b1;
      dsv_pkg::CLS_PULSE:
        if (mode_r == dsv_pkg::PFX_TONE && cfg.mode_switch_reject) illegal = 1'b1;
      dsv_pkg::CLS_CARET:
        if (cfg.calling_tone_mode == dsv_pkg::CARET_REJECT_MODE) illegal = 1'b1;
      dsv_pkg::CLS_SEMI:  ;
      default:            illegal = 1'b1;
    endcase
  end

  assign floor_grade = cfg.lenient_validation ? dsv_pkg::GRADE_TOLERABLE
                                              : dsv_pkg::GRADE_INVALID;

  // next state
  always_comb begin
    mode_nxt  = mode_r;
    cnt_nxt   = cnt_r;
    grade_nxt = grade_r;
    last_nxt  = last_r;
    semi_nxt  = semi_r;
    if (fire) begin
      if (kind == dsv_pkg::KIND_END) begin
        mode_nxt  = dsv_pkg::PFX_WAIT;
        cnt_nxt   = '0;
        grade_nxt = dsv_pkg::GRADE_VALID;
        last_nxt  = dsv_pkg::POS_NONE;
        semi_nxt  = 1'b0;
      end else begin
        if (cnt_r != dsv_pkg::CNT_SAT) cnt_nxt = cnt_r + 1'b1;
        if (mode_r == dsv_pkg::PFX_WAIT) begin
          if (cls == dsv_pkg::CLS_TONE) mode_nxt = dsv_pkg::PFX_TONE;
          else if (cls == dsv_pkg::CLS_PULSE) mode_nxt = dsv_pkg::PFX_PULSE;
          else mode_nxt = dsv_pkg::PFX_NONE;
        end else if (mode_r != dsv_pkg::PFX_NONE) begin
          semi_nxt = (cls == dsv_pkg::CLS_SEMI);
          if (illegal && grade_r > floor_grade) grade_nxt = floor_grade;
          if (dialable) last_nxt = {1'b0, cnt_r};
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= dsv_pkg::PFX_WAIT;
      cnt_r   <= '0;
      grade_r <= dsv_pkg::GRADE_VALID;
      last_r  <= dsv_pkg::POS_NONE;
      semi_r  <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      cnt_r   <= cnt_nxt;
      grade_r <= grade_nxt;
      last_r  <= last_nxt;
      semi_r  <= semi_nxt;
    end
  end

  // end-of-string result from the current state
  always_comb begin
    res.last_pos = dsv_pkg::POS_NONE;
    if (cnt_r > dsv_pkg::CNT_W'(dsv_pkg::MAX_LEN)) begin
      res.grade = dsv_pkg::GRADE_FATAL;
    end else if (mode_r == dsv_pkg::PFX_WAIT) begin
      res.grade = dsv_pkg::GRADE_VALID;
    end else if (mode_r == dsv_pkg::PFX_NONE) begin
      res.grade = dsv_pkg::GRADE_INVALID;
    end else begin
      res.grade    = grade_r;
      res.last_pos = last_r;
    end
    res.rejected = (res.grade == dsv_pkg::GRADE_FATAL) ||
                   (res.grade == dsv_pkg::GRADE_INVALID);
  end

endmodule

`default_nettype wire

@@ design/dial_string_validator_core.sv @@
// top level of the dial string validator: input register, config, result register
//
//  channel | ports                                              | dir
//  --------+----------------------------------------------------+-----
//  in      | in_valid in_ready in_kind in_symbol                | in
//  out     | out_valid out_ready out_grade out_rejected         | out
//          | out_last_dialable_position                         |
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data             | in
//
// one transaction per cycle while the input does not stall; a transaction is held in the input register,
// and an end transaction's result is loaded into the result register as that transaction fires.
// character transactions never wait in the input register; an end transaction waits
// there only while the result register holds a result not yet taken, and the input
// stalls behind it.
// synchronous active-low reset clears all control state and the config registers.
// cfg writes are taken every cycle; indexes above three are dropped.
`default_nettype none

module dial_string_validator_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_kind,
  input  wire logic [dsv_pkg::SYM_W-1:0]        in_symbol,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [1:0]                            out_grade,
  output logic                                  out_rejected,
  output logic signed [dsv_pkg::POS_W-1:0]      out_last_dialable_position,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [dsv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dsv_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic                          in_vld_r;
  logic                          in_kind_r;
  logic [dsv_pkg::SYM_W-1:0]     in_sym_r;
  logic                          fire;
  dsv_pkg::cfg_t                 cfg_r;
  dsv_pkg::res_t                 res;
  logic                          out_vld_r;
  dsv_pkg::res_t                 out_res_r;

  // process the held transaction unless it is an end blocked by a full result register
  assign fire     = in_vld_r && (in_kind_r == dsv_pkg::KIND_CHAR || !out_vld_r || out_ready);
  assign in_ready = !in_vld_r || fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_kind_r <= in_kind;
      in_sym_r  <= in_symbol;
    end
  end

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        dsv_pkg::CFG_ABCD_REJECT:        cfg_r.abcd_reject        <= cfg_data[0];
        dsv_pkg::CFG_MODE_SWITCH_REJECT: cfg_r.mode_switch_reject <= cfg_data[0];
        dsv_pkg::CFG_CALLING_TONE_MODE:  cfg_r.calling_tone_mode  <= cfg_data[2:0];
        dsv_pkg::CFG_LENIENT_VALIDATION: cfg_r.lenient_validation <= cfg_data[0];
        default: ;
      endcase
    end
  end

  dsv_tracker u_trk (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .kind   (in_kind_r),
    .symbol (in_sym_r),
    .cfg    (cfg_r),
    .res    (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire && in_kind_r == dsv_pkg::KIND_END) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_kind_r == dsv_pkg::KIND_END) begin
      out_res_r <= res;
    end
  end

  assign out_valid                  = out_vld_r;
  assign out_grade                  = out_res_r.grade;
  assign out_rejected               = out_res_r.rejected;
  assign out_last_dialable_position = out_res_r.last_pos;

endmodule

`default_nettype wire

@@ design/dsv_checker.sv @@
// port-level checks for the dial string validator and their bind
`default_nettype none

module dsv_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [1:0]                       out_grade,
  input wire logic                             out_rejected,
  input wire logic signed [dsv_pkg::POS_W-1:0] out_last_dialable_position
);

  // rejected flag agrees with the grade
  a_rejected_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rejected == ((out_grade == dsv_pkg::GRADE_FATAL) ||
                                   (out_grade == dsv_pkg::GRADE_INVALID)))
    else $error("rejected flag disagrees with grade");

  // a fatal string reports no dialable position
  a_fatal_no_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_grade == dsv_pkg::GRADE_FATAL) |->
      out_last_dialable_position == dsv_pkg::POS_NONE)
    else $error("fatal result carries a dialable position");

  // a reported position lies inside the length limit
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_dialable_position != dsv_pkg::POS_NONE) |->
      (!out_last_dialable_position[dsv_pkg::POS_W-1] &&
       out_last_dialable_position < dsv_pkg::POS_W'(dsv_pkg::MAX_LEN)))
    else $error("dialable position out of range");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_grade) && $stable(out_last_dialable_position)))
    else $error("result changed while stalled");

  // input side keeps moving whenever the result register can take a result
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && (!out_valid || out_ready)) |-> in_ready)
    else $error("input stalled although the result side is free");

endmodule

bind dial_string_validator_core dsv_checker u_dsv_chk (
  .clk                        (clk),
  .rst_n                      (rst_n),
  .in_valid                   (in_valid),
  .in_ready                   (in_ready),
  .out_valid                  (out_valid),
  .out_ready                  (out_ready),
  .out_grade                  (out_grade),
  .out_rejected               (out_rejected),
  .out_last_dialable_position (out_last_dialable_position)
);

`default_nettype wire
